[rtl/core/fbps_pkg.sv]
`default_nettype none
package fbps_pkg;

  localparam int COLUMNS  = 128;
  localparam int PAGES    = 8;
  localparam int ROWS     = PAGES * 8;
  localparam int PAGE_LEN = COLUMNS + 3;
  localparam int DEPTH    = COLUMNS * PAGES;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int OW       = $clog2(PAGE_LEN);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [2:0] {
    OP_POINT   = 3'd0,
    OP_HLINE   = 3'd1,
    OP_VLINE   = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_REFRESH = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] span_end;
    logic       pixel_on;
  } fbps_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } fbps_out_t;

  // what the refresh counter offers for the current stream position
  typedef struct packed {
    logic          is_cmd;
    logic [7:0]    cmd_byte;
    logic [AW-1:0] addr;
    logic          last;
  } fbps_ref_t;

  function automatic logic [AW-1:0] fbps_addr(input logic [7:0] page, input logic [8:0] col);
    int unsigned a;
    a = int'(page) * COLUMNS + int'(col);
    return a[AW-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/fbps_ram.sv]
`default_nettype none
module fbps_ram
  import fbps_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/fbps_refresh.sv]
`default_nettype none
module fbps_refresh
  import fbps_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  output fbps_ref_t ref_o
);

  logic [PW-1:0] page_q, page_d;
  logic [OW-1:0] off_q, off_d;
  logic          page_end;

  assign page_end = (off_q == OW'(PAGE_LEN - 1));

  always_comb begin
    ref_o.is_cmd = (off_q < OW'(3));
    ref_o.last   = page_end && (page_q == PW'(PAGES - 1));
    ref_o.addr   = fbps_addr(8'(page_q), 9'(off_q) - 9'd3);
    if (off_q == OW'(0)) begin
      ref_o.cmd_byte = CMD_PAGE_BASE + 8'(page_q);
    end else if (off_q == OW'(1)) begin
      ref_o.cmd_byte = CMD_COL_LOW;
    end else begin
      ref_o.cmd_byte = CMD_COL_HIGH;
    end
  end

  always_comb begin
    page_d = page_q;
    off_d  = off_q;
    if (step_i) begin
      if (page_end) begin
        off_d  = '0;
        page_d = ref_o.last ? '0 : page_q + PW'(1);
      end else begin
        off_d = off_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      off_q  <= '0;
    end else begin
      page_q <= page_d;
      off_q  <= off_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mono_framebuffer_page_streamer.sv]
`default_nettype none
// Monochrome frame store with a page-mode refresh byte stream.
// Input: an item is taken when start is high and busy is low. Results
// leave on result_o for exactly one cycle, marked by strobe_o; the
// receiver cannot hold them off, and at most one item is in flight.
// Work per item, on the frame memory (one write port, one read port),
// which is shared by drawing, refresh and the clear sweep:
//   refresh command byte: result the cycle after acceptance
//   refresh data byte: memory read, then result from ST_FETCH
//   point: a read then a write; off-frame point or empty line: no access
//   line: a read then a write for each pixel drawn
//   clear: a write to each of the COLUMNS*PAGES addresses (1024 at 128x8)
//   unused operation codes: no result
// After reset the memory is zeroed by a sweep of all COLUMNS*PAGES
// addresses (1024 at 128x8) with busy high; the refresh position starts at the
// first command of page 0. Clear leaves the refresh position alone.
module mono_framebuffer_page_streamer
  import fbps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire fbps_in_t item_i,
  output logic          busy,
  output logic          strobe_o,
  output fbps_out_t     result_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_MODIFY = 5'b01000,
    ST_FETCH  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  logic [7:0]    x_q, x_d, y_q, y_d, end_q, end_d;
  logic          on_q, on_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          last_q, last_d;
  logic          strobe_q, strobe_d;
  fbps_out_t     out_q, out_d;

  logic          accept, step;
  fbps_ref_t     ref_info;
  logic          we, re;
  logic [AW-1:0] waddr, raddr, pix_addr;
  logic [7:0]    wdata, rdata, mask;
  logic          x_ok, y_ok, line_done;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign step   = accept && (op_e'(item_i.operation) == OP_REFRESH);

  fbps_refresh u_refresh (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ref_o  (ref_info)
  );

  fbps_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign x_ok     = ({1'b0, item_i.pos_x} < 9'(COLUMNS));
  assign y_ok     = ({1'b0, item_i.pos_y} < 9'(ROWS));
  assign pix_addr = fbps_addr({3'b000, y_q[7:3]}, {1'b0, x_q});
  assign mask     = 8'd1 << y_q[2:0];

  // stop at the end coordinate or at the frame edge, whichever comes first
  always_comb begin
    if (op_q == OP_HLINE) begin
      line_done = (x_q == end_q) || (({1'b0, x_q} + 9'd1) >= 9'(COLUMNS));
    end else if (op_q == OP_VLINE) begin
      line_done = (y_q == end_q) || (({1'b0, y_q} + 9'd1) >= 9'(ROWS));
    end else begin
      line_done = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    x_d      = x_q;
    y_d      = y_q;
    end_d    = end_q;
    on_d     = on_q;
    clr_d    = clr_q;
    last_d   = last_q;
    strobe_d = 1'b0;
    out_d    = out_q;
    we       = 1'b0;
    waddr    = pix_addr;
    wdata    = on_q ? (rdata | mask) : (rdata & ~mask);
    re       = 1'b0;
    raddr    = pix_addr;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_d  = op_e'(item_i.operation);
          x_d   = item_i.pos_x;
          y_d   = item_i.pos_y;
          end_d = item_i.span_end;
          unique case (op_e'(item_i.operation))
            OP_POINT: begin
              on_d = item_i.pixel_on;
              if (x_ok && y_ok) begin
                state_d = ST_READ;
              end
            end
            OP_HLINE: begin
              on_d = 1'b1;
              if (x_ok && y_ok && (item_i.pos_x <= item_i.span_end)) begin
                state_d = ST_READ;
              end
            end
            OP_VLINE: begin
              on_d = 1'b1;
              if (x_ok && y_ok && (item_i.pos_y <= item_i.span_end)) begin
                state_d = ST_READ;
              end
            end
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_REFRESH: begin
              last_d = ref_info.last;
              if (ref_info.is_cmd) begin
                strobe_d           = 1'b1;
                out_d.out_byte     = ref_info.cmd_byte;
                out_d.is_data      = 1'b0;
                out_d.frame_end    = 1'b0;
              end else begin
                re      = 1'b1;
                raddr   = ref_info.addr;
                state_d = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        re      = 1'b1;
        state_d = ST_MODIFY;
      end

      ST_MODIFY: begin
        we = 1'b1;
        if (line_done) begin
          state_d = ST_IDLE;
        end else begin
          if (op_q == OP_HLINE) begin
            x_d = x_q + 8'd1;
          end else begin
            y_d = y_q + 8'd1;
          end
          state_d = ST_READ;
        end
      end

      ST_FETCH: begin
        strobe_d        = 1'b1;
        out_d.out_byte  = rdata;
        out_d.is_data   = 1'b1;
        out_d.frame_end = last_q;
        state_d         = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    x_q    <= x_d;
    y_q    <= y_d;
    end_q  <= end_d;
    on_q   <= on_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign strobe_o = strobe_q;
  assign result_o = out_q;

endmodule
`default_nettype wire

[bench/mono_framebuffer_page_streamer_test.sv]
module mono_framebuffer_page_streamer_test;
  import fbps_pkg::*;

  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 1100;
  localparam int          RANDOM_ITEMS = 1330;
  localparam int          SCAN_LEN     = PAGES * PAGE_LEN;
  localparam logic [2:0]  OP_SPARE_A   = 3'd5;
  localparam logic [2:0]  OP_SPARE_B   = 3'd6;
  localparam logic [2:0]  OP_SPARE_C   = 3'd7;

  typedef struct {
    fbps_in_t  item;
    bit        typed;
    fbps_out_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  fbps_in_t  item_i;
  logic      busy;
  logic      strobe_o;
  fbps_out_t result_o;

  logic [7:0] pix_mem [DEPTH];
  int         scan_pos;
  int         frames_done;
  fbps_out_t  expected_bytes [$];
  int         mismatches;
  int         cycles;
  bit         idle_on;
  dir_row_t   dir_rows [25];

  mono_framebuffer_page_streamer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .strobe_o(strobe_o),
    .result_o(result_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  function automatic void put_pixel(input int x, input int y, input bit on);
    int idx;
    if (x >= COLUMNS || y >= ROWS) return;
    idx = (y / 8) * COLUMNS + x;
    pix_mem[idx][y % 8] = on;
  endfunction

  // advances the frame store and scan position by one item
  function automatic void apply_item(input fbps_in_t it, output bit emits,
                                     output fbps_out_t res);
    int k;
    int page;
    int off;
    emits = 1'b0;
    res   = '0;
    case (it.operation)
      OP_POINT: put_pixel(it.pos_x, it.pos_y, it.pixel_on);
      OP_HLINE: for (k = it.pos_x; k <= it.span_end; k++) put_pixel(k, it.pos_y, 1'b1);
      OP_VLINE: for (k = it.pos_y; k <= it.span_end; k++) put_pixel(it.pos_x, k, 1'b1);
      OP_CLEAR: for (k = 0; k < DEPTH; k++) pix_mem[k] = '0;
      OP_REFRESH: begin
        emits = 1'b1;
        page  = scan_pos / PAGE_LEN;
        off   = scan_pos % PAGE_LEN;
        if (off == 0) begin
          res.out_byte = CMD_PAGE_BASE + 8'(page);
        end else if (off == 1) begin
          res.out_byte = CMD_COL_LOW;
        end else if (off == 2) begin
          res.out_byte = CMD_COL_HIGH;
        end else begin
          res.out_byte = pix_mem[page * COLUMNS + off - 3];
          res.is_data  = 1'b1;
        end
        scan_pos++;
        if (scan_pos >= SCAN_LEN) begin
          scan_pos      = 0;
          res.frame_end = 1'b1;
          frames_done++;
        end
      end
      default: ;
    endcase
  endfunction

  // called in the step of a rising edge; returns in the step of the accepting edge
  task automatic issue(input fbps_in_t it, input bit typed, input fbps_out_t typed_res);
    fbps_out_t res;
    bit        emits;
    if (idle_on && $urandom_range(0, 99) < 34) begin
      start  <= 1'b0;
      item_i <= fbps_in_t'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_item(it, emits, res);
    if (emits) expected_bytes.push_back(typed ? typed_res : res);
  endtask

  function automatic dir_row_t mk(input logic [2:0] op, input logic [7:0] x,
                                  input logic [7:0] y, input logic [7:0] e,
                                  input logic on, input bit typed,
                                  input logic [7:0] b, input logic d);
    dir_row_t r;
    r.item  = '{operation: op, pos_x: x, pos_y: y, span_end: e, pixel_on: on};
    r.typed = typed;
    r.want  = '{out_byte: b, is_data: d, frame_end: 1'b0};
    return r;
  endfunction

  always @(posedge clk_i) begin : check_results
    fbps_out_t want;
    if (rst_ni && strobe_o === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %h with no item pending", result_o.out_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (result_o.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, expected %h",
                                    result_o.out_byte, want.out_byte));
        if (result_o.is_data !== want.is_data)
          report_mismatch($sformatf("is_data %b, expected %b",
                                    result_o.is_data, want.is_data));
        if (result_o.frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, expected %b",
                                    result_o.frame_end, want.frame_end));
      end
    end
  end

  initial begin : stimulus
    int        n;
    int        sel;
    fbps_in_t  it;
    fbps_out_t none;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cycles      = 0;
    mismatches  = 0;
    scan_pos    = 0;
    frames_done = 0;
    idle_on     = 1'b1;
    none        = '0;
    for (n = 0; n < DEPTH; n++) pix_mem[n] = '0;

    dir_rows[0]  = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 1, CMD_PAGE_BASE, 1'b0);
    dir_rows[1]  = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 1, CMD_COL_LOW, 1'b0);
    dir_rows[2]  = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 1, CMD_COL_HIGH, 1'b0);
    dir_rows[3]  = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 1, 8'h00, 1'b1);
    dir_rows[4]  = mk(OP_POINT, 8'd1, 8'd0, 8'd0, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[5]  = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 1, 8'h01, 1'b1);
    // pixels off the frame are dropped
    dir_rows[6]  = mk(OP_POINT, 8'd255, 8'd255, 8'd255, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[7]  = mk(OP_POINT, 8'd127, 8'd63, 8'd0, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[8]  = mk(OP_POINT, 8'd128, 8'd0, 8'd0, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[9]  = mk(OP_POINT, 8'd0, 8'd64, 8'd0, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[10] = mk(OP_HLINE, 8'd0, 8'd2, 8'd255, 1'b0, 0, 8'h00, 1'b0);
    dir_rows[11] = mk(OP_VLINE, 8'd2, 8'd0, 8'd63, 1'b0, 0, 8'h00, 1'b0);
    // reversed lines draw nothing
    dir_rows[12] = mk(OP_HLINE, 8'd10, 8'd3, 8'd5, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[13] = mk(OP_VLINE, 8'd4, 8'd40, 8'd39, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[14] = mk(OP_POINT, 8'd2, 8'd2, 8'd255, 1'b0, 0, 8'h00, 1'b0);
    dir_rows[15] = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 0, 8'h00, 1'b0);
    dir_rows[16] = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 0, 8'h00, 1'b0);
    dir_rows[17] = mk(OP_SPARE_A, 8'd255, 8'd255, 8'd255, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[18] = mk(OP_SPARE_B, 8'd0, 8'd0, 8'd0, 1'b0, 0, 8'h00, 1'b0);
    dir_rows[19] = mk(OP_SPARE_C, 8'd255, 8'd255, 8'd255, 1'b1, 0, 8'h00, 1'b0);
    // clear keeps the scan position
    dir_rows[20] = mk(OP_CLEAR, 8'd255, 8'd255, 8'd255, 1'b1, 0, 8'h00, 1'b0);
    dir_rows[21] = mk(OP_REFRESH, 8'd0, 8'd0, 8'd0, 1'b0, 1, 8'h00, 1'b1);
    dir_rows[22] = mk(OP_REFRESH, 8'd255, 8'd255, 8'd255, 1'b1, 1, 8'h00, 1'b1);
    dir_rows[23] = mk(OP_HLINE, 8'd120, 8'd63, 8'd255, 1'b0, 0, 8'h00, 1'b0);
    dir_rows[24] = mk(OP_VLINE, 8'd127, 8'd60, 8'd200, 1'b0, 0, 8'h00, 1'b0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // let the directed items drain before the random part
    start <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);

    n = 0;
    while (n < RANDOM_ITEMS || frames_done == 0) begin
      idle_on = !(n >= 400 && n < 700);
      if (n == 700) begin
        start <= 1'b0;
        do @(posedge clk_i); while (expected_bytes.size() != 0);
      end
      it          = fbps_in_t'($urandom);
      it.pos_x    = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, COLUMNS - 1))
                                                 : 8'($urandom_range(0, 255));
      it.pos_y    = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, ROWS - 1))
                                                 : 8'($urandom_range(0, 255));
      sel = $urandom_range(0, 99);
      if (sel < 76) begin
        it.operation = OP_REFRESH;
      end else if (sel < 85) begin
        it.operation = OP_POINT;
      end else if (sel < 90) begin
        it.operation = OP_HLINE;
        // mostly short lines, now and then a wild end point
        if ($urandom_range(0, 9) != 0)
          it.span_end = (it.pos_x > 231) ? 8'd255 : it.pos_x + 8'($urandom_range(0, 24));
      end else if (sel < 95) begin
        it.operation = OP_VLINE;
        if ($urandom_range(0, 9) != 0)
          it.span_end = (it.pos_y > 231) ? 8'd255 : it.pos_y + 8'($urandom_range(0, 24));
      end else if (sel < 96) begin
        it.operation = OP_CLEAR;
      end else begin
        it.operation = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
      end
      issue(it, 1'b0, none);
      n++;
    end

    start <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never produced", expected_bytes.size()));
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
